### rtl/core/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned PtrW       = $clog2(StackDepth);
  localparam int unsigned DepthW     = $clog2(StackDepth + 1);
  localparam int unsigned DataW      = 32;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_DIVZERO  = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

endpackage

`default_nettype wire

### rtl/core/rpn_ram.sv
`default_nettype none

module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/rpn_divider.sv
`default_nettype none

module rpn_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rpn_pkg::DataW-1:0]  dividend_i,
  input  wire logic [rpn_pkg::DataW-1:0]  divisor_i,
  output logic                            done_o,
  output logic      [rpn_pkg::DataW-1:0]  quotient_o
);

  localparam int unsigned CntW = $clog2(rpn_pkg::DataW);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [rpn_pkg::DataW-1:0] rem_q, rem_d;
  logic [rpn_pkg::DataW-1:0] quo_q, quo_d;
  logic [rpn_pkg::DataW-1:0] dsr_q, dsr_d;
  logic                      neg_q, neg_d;
  logic [rpn_pkg::DataW:0]   shifted;
  logic [rpn_pkg::DataW:0]   diff;

  assign shifted = {rem_q, quo_q[rpn_pkg::DataW-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[rpn_pkg::DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
      dsr_d  = divisor_i[rpn_pkg::DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_d  = dividend_i[rpn_pkg::DataW-1] ^ divisor_i[rpn_pkg::DataW-1];
    end else if (busy_q) begin
      rem_d = diff[rpn_pkg::DataW] ? shifted[rpn_pkg::DataW-1:0] : diff[rpn_pkg::DataW-1:0];
      quo_d = {quo_q[rpn_pkg::DataW-2:0], ~diff[rpn_pkg::DataW]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(rpn_pkg::DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

### rtl/core/rpn_stack_evaluator_unit.sv
`default_nettype none

// Channel  Direction  Handshake                 Payload
// input    in         in_valid_i / in_ready_o   char_in_i[7:0], last_char_i
// output   out        out_valid_o / out_ready_i value_o[31:0] signed, status_o[1:0]
//
// A whitespace or a digit stays in idle; an add, subtract or multiply also passes the read state
// (the operand below the top is a registered read from the stack memory).
// A divide then waits in the divide state for the 32 iterations of the restoring divider.
// The last character of an expression leads to ST_FIN, which loads the output register.
// Reset clears the control state at once; the stack memory needs no clearing pass.
// A result waiting on out_ready_i does not block input until the next expression ends.

module rpn_stack_evaluator_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         char_in_i,
  input  wire logic               last_char_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      value_o,
  output logic        [1:0]       status_o
);

  rpn_pkg::state_e  state_q, state_d;
  rpn_pkg::status_e err_q, err_d;
  rpn_pkg::op_e     op_q, op_d;
  logic [rpn_pkg::DepthW-1:0] depth_q, depth_d;
  logic [rpn_pkg::DataW-1:0]  tos_q, tos_d;
  logic [7:0]                 pend_char_q, pend_char_d;
  logic [1:0]                 pend_len_q, pend_len_d;
  logic                       last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  logic [rpn_pkg::DataW-1:0]  value_q, value_d;
  rpn_pkg::status_e           status_q, status_d;

  logic       accept;
  logic       is_space;
  logic [7:0] tok_char;
  logic [1:0] tok_len;
  logic [7:0] new_char;
  logic [1:0] new_len;
  logic       tok_push;
  logic       tok_op;
  logic       tok_bad;
  rpn_pkg::op_e tok_opc;

  logic                       mem_we;
  logic [rpn_pkg::PtrW-1:0]   mem_waddr;
  logic                       mem_re;
  logic [rpn_pkg::PtrW-1:0]   mem_raddr;
  logic [rpn_pkg::DataW-1:0]  mem_rdata;
  logic [rpn_pkg::DepthW-1:0] wr_idx;
  logic [rpn_pkg::DepthW-1:0] rd_idx;

  logic                      div_start;
  logic                      div_done;
  logic [rpn_pkg::DataW-1:0] div_quo;
  logic [rpn_pkg::DataW-1:0] mul_lo;
  logic                      slot_free;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == rpn_pkg::ST_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;
  assign wr_idx    = depth_q - rpn_pkg::DepthW'(1);
  assign rd_idx    = depth_q - rpn_pkg::DepthW'(2);
  assign mem_waddr = wr_idx[rpn_pkg::PtrW-1:0];
  assign mem_raddr = rd_idx[rpn_pkg::PtrW-1:0];
  assign mul_lo    = mem_rdata * tos_q;

  always_comb begin
    is_space = (char_in_i == rpn_pkg::CharSpace) ||
               (char_in_i inside {[rpn_pkg::CharTab : rpn_pkg::CharCr]});
    new_char = (pend_len_q == 2'd0) ? char_in_i : pend_char_q;
    new_len  = (pend_len_q == 2'd0) ? 2'd1 : 2'd2;
    if (is_space) begin
      tok_char = pend_char_q;
      tok_len  = pend_len_q;
    end else if (last_char_i) begin
      tok_char = new_char;
      tok_len  = new_len;
    end else begin
      tok_char = new_char;
      tok_len  = 2'd0;
    end
  end

  always_comb begin
    tok_push = 1'b0;
    tok_op   = 1'b0;
    tok_bad  = 1'b0;
    tok_opc  = rpn_pkg::OP_ADD;
    if (tok_len != 2'd0 && err_q == rpn_pkg::STATUS_OK) begin
      if (tok_len != 2'd1) begin
        tok_bad = 1'b1;
      end else if (tok_char inside {[rpn_pkg::CharZero : rpn_pkg::CharNine]}) begin
        tok_push = 1'b1;
      end else begin
        case (tok_char)
          rpn_pkg::CharPlus:  tok_opc = rpn_pkg::OP_ADD;
          rpn_pkg::CharMinus: tok_opc = rpn_pkg::OP_SUB;
          rpn_pkg::CharStar:  tok_opc = rpn_pkg::OP_MUL;
          rpn_pkg::CharSlash: tok_opc = rpn_pkg::OP_DIV;
          default:            tok_bad = 1'b1;
        endcase
        tok_op = !tok_bad;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rpn_pkg::ST_IDLE: begin
        if (accept) begin
          if (tok_op && depth_q >= rpn_pkg::DepthW'(2)) begin
            state_d = rpn_pkg::ST_READ;
          end else if (last_char_i) begin
            state_d = rpn_pkg::ST_FIN;
          end
        end
      end
      rpn_pkg::ST_READ: begin
        if (op_q == rpn_pkg::OP_DIV && tos_q != '0) begin
          state_d = rpn_pkg::ST_DIV;
        end else begin
          state_d = last_q ? rpn_pkg::ST_FIN : rpn_pkg::ST_IDLE;
        end
      end
      rpn_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = last_q ? rpn_pkg::ST_FIN : rpn_pkg::ST_IDLE;
        end
      end
      rpn_pkg::ST_FIN: begin
        if (slot_free) begin
          state_d = rpn_pkg::ST_IDLE;
        end
      end
      default: state_d = rpn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    err_d       = err_q;
    op_d        = op_q;
    depth_d     = depth_q;
    tos_d       = tos_q;
    pend_char_d = pend_char_q;
    pend_len_d  = pend_len_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      rpn_pkg::ST_IDLE: begin
        if (accept) begin
          last_d = last_char_i;
          if (is_space || last_char_i) begin
            pend_char_d = '0;
            pend_len_d  = 2'd0;
          end else begin
            pend_char_d = new_char;
            pend_len_d  = new_len;
          end
          if (tok_bad) begin
            err_d = rpn_pkg::STATUS_INVALID;
          end else if (tok_push) begin
            if (depth_q == rpn_pkg::DepthW'(rpn_pkg::StackDepth)) begin
              err_d = rpn_pkg::STATUS_OVERFLOW;
            end else begin
              mem_we  = (depth_q != '0);
              tos_d   = rpn_pkg::DataW'(tok_char - rpn_pkg::CharZero);
              depth_d = depth_q + rpn_pkg::DepthW'(1);
            end
          end else if (tok_op) begin
            if (depth_q < rpn_pkg::DepthW'(2)) begin
              err_d = rpn_pkg::STATUS_INVALID;
            end else begin
              mem_re = 1'b1;
              op_d   = tok_opc;
            end
          end
        end
      end
      rpn_pkg::ST_READ: begin
        case (op_q)
          rpn_pkg::OP_ADD: begin
            tos_d   = mem_rdata + tos_q;
            depth_d = depth_q - rpn_pkg::DepthW'(1);
          end
          rpn_pkg::OP_SUB: begin
            tos_d   = mem_rdata - tos_q;
            depth_d = depth_q - rpn_pkg::DepthW'(1);
          end
          rpn_pkg::OP_MUL: begin
            tos_d   = mul_lo;
            depth_d = depth_q - rpn_pkg::DepthW'(1);
          end
          rpn_pkg::OP_DIV: begin
            if (tos_q == '0) begin
              err_d = rpn_pkg::STATUS_DIVZERO;
            end else begin
              div_start = 1'b1;
            end
          end
          default: err_d = rpn_pkg::STATUS_INVALID;
        endcase
      end
      rpn_pkg::ST_DIV: begin
        if (div_done) begin
          tos_d   = div_quo;
          depth_d = depth_q - rpn_pkg::DepthW'(1);
        end
      end
      rpn_pkg::ST_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (err_q != rpn_pkg::STATUS_OK) begin
            status_d = err_q;
            value_d  = '0;
          end else if (depth_q != rpn_pkg::DepthW'(1)) begin
            status_d = rpn_pkg::STATUS_INVALID;
            value_d  = '0;
          end else begin
            status_d = rpn_pkg::STATUS_OK;
            value_d  = tos_q;
          end
          err_d       = rpn_pkg::STATUS_OK;
          depth_d     = '0;
          pend_char_d = '0;
          pend_len_d  = 2'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpn_pkg::ST_IDLE;
      err_q       <= rpn_pkg::STATUS_OK;
      depth_q     <= '0;
      pend_char_q <= '0;
      pend_len_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      depth_q     <= depth_d;
      pend_char_q <= pend_char_d;
      pend_len_q  <= pend_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tos_q    <= tos_d;
    last_q   <= last_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  rpn_ram #(
    .Width (rpn_pkg::DataW),
    .Depth (rpn_pkg::StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (tos_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rpn_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mem_rdata),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_read_needs_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rpn_pkg::ST_READ |-> depth_q >= rpn_pkg::DepthW'(2))
    else $error("operator read issued with fewer than two stack entries");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == rpn_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> depth_q < rpn_pkg::DepthW'(rpn_pkg::StackDepth) && state_q == rpn_pkg::ST_IDLE)
    else $error("stack write beyond capacity or outside a push");

  a_err_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rpn_pkg::STATUS_OK |-> value_o == '0)
    else $error("error result carries a nonzero value");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;
  import rpn_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxErrLines = 100;

  typedef struct packed {
    logic [31:0] value;
    status_e     status;
  } expr_result_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         char_in   = 8'd0;
  logic               last_char = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] dut_value;
  logic [1:0]         dut_status;

  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned error_count;
  int unsigned chars_sent;
  int unsigned results_checked;
  int unsigned status_seen [4];

  logic [31:0]  eval_stack [StackDepth];
  int unsigned  eval_depth;
  logic [7:0]   token_char = 8'd0;
  int unsigned  token_len;
  status_e      expr_error = STATUS_OK;
  expr_result_t expr_results_q [$];
  logic [7:0]   expr_chars [$];

  rpn_stack_evaluator_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .char_in_i   (char_in),
    .last_char_i (last_char),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .value_o     (dut_value),
    .status_o    (dut_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxErrLines) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic bit is_space(input logic [7:0] c);
    return c == CharSpace || (c >= CharTab && c <= CharCr);
  endfunction

  function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quo;
    mag_a = a[31] ? 32'd0 - a : a;
    mag_b = b[31] ? 32'd0 - b : b;
    quo   = mag_a / mag_b;
    return (a[31] != b[31]) ? 32'd0 - quo : quo;
  endfunction

  function automatic void close_token();
    logic [7:0]  c;
    int unsigned len;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    c          = token_char;
    len        = token_len;
    token_char = 8'd0;
    token_len  = 0;
    if (len == 0 || expr_error != STATUS_OK) return;
    if (len != 1) begin
      expr_error = STATUS_INVALID;
      return;
    end
    if (c >= CharZero && c <= CharNine) begin
      if (eval_depth >= StackDepth) begin
        expr_error = STATUS_OVERFLOW;
        return;
      end
      eval_stack[eval_depth] = {24'd0, 8'(c - CharZero)};
      eval_depth++;
      return;
    end
    if (c == CharPlus || c == CharMinus || c == CharStar || c == CharSlash) begin
      if (eval_depth < 2) begin
        expr_error = STATUS_INVALID;
        return;
      end
      b = eval_stack[eval_depth - 1];
      a = eval_stack[eval_depth - 2];
      case (c)
        CharPlus:  r = a + b;
        CharMinus: r = a - b;
        CharStar:  r = a * b;
        default: begin
          if (b == 32'd0) begin
            expr_error = STATUS_DIVZERO;
            return;
          end
          r = div_trunc(a, b);
        end
      endcase
      eval_depth--;
      eval_stack[eval_depth - 1] = r;
      return;
    end
    expr_error = STATUS_INVALID;
  endfunction

  function automatic void absorb_char(input logic [7:0] c, input logic last);
    expr_result_t res;
    if (is_space(c)) begin
      close_token();
    end else begin
      if (token_len == 0) token_char = c;
      if (token_len < 2) token_len++;
    end
    if (!last) return;
    close_token();
    res.value  = 32'd0;
    res.status = expr_error;
    if (expr_error == STATUS_OK) begin
      if (eval_depth != 1) res.status = STATUS_INVALID;
      else res.value = eval_stack[0];
    end
    expr_results_q.push_back(res);
    eval_depth = 0;
    expr_error = STATUS_OK;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin : result_check
    expr_result_t exp_res;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expr_results_q.size() == 0) begin
        report_mismatch($sformatf("result value=%0d status=%0d with nothing expected",
                                  dut_value, dut_status));
      end else begin
        exp_res = expr_results_q.pop_front();
        results_checked++;
        status_seen[exp_res.status]++;
        if (dut_status !== exp_res.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", dut_status, exp_res.status));
        end
        if (dut_value !== exp_res.value) begin
          report_mismatch($sformatf("value %0d, expected %0d", dut_value,
                                    $signed(exp_res.value)));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_in   <= c;
    last_char <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    absorb_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_chars.size(); i++) begin
      send_char(expr_chars[i], i == expr_chars.size() - 1);
    end
    expr_chars.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expr_results_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_ws();
    return ($urandom_range(1) == 1) ? CharSpace : 8'(CharTab + $urandom_range(4));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CharZero + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(3))
      0:       return CharPlus;
      1:       return CharMinus;
      2:       return CharStar;
      default: return CharSlash;
    endcase
  endfunction

  function automatic void add_sep();
    int unsigned n;
    n = ($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1;
    repeat (n) expr_chars.push_back(rand_ws());
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endfunction

  // 2 * 8**10 wraps to the most negative value.
  function automatic void queue_min_value();
    queue_text("2");
    repeat (10) queue_text(" 8 *");
  endfunction

  function automatic void build_wellformed(input int unsigned n_operands,
                                           input bit pushes_first);
    int unsigned pushes_left;
    int unsigned depth;
    bit          first;
    pushes_left = n_operands;
    depth       = 0;
    first       = 1'b1;
    if ($urandom_range(3) == 0) add_sep();
    while (pushes_left > 0 || depth > 1) begin
      if (!first) add_sep();
      first = 1'b0;
      if (depth >= 2 && (pushes_left == 0 || (!pushes_first && $urandom_range(1) == 1))) begin
        expr_chars.push_back(rand_op());
        depth--;
      end else begin
        expr_chars.push_back(rand_digit());
        pushes_left--;
        depth++;
      end
    end
    if ($urandom_range(1) == 1) add_sep();
  endfunction

  function automatic void build_noise();
    int unsigned n_tokens;
    n_tokens = $urandom_range(6);
    for (int i = 0; i < n_tokens; i++) begin
      if (i != 0 || $urandom_range(1) == 1) add_sep();
      case ($urandom_range(4))
        0: expr_chars.push_back(8'($urandom_range(255)));
        1: begin
          repeat ($urandom_range(3, 2)) begin
            expr_chars.push_back(($urandom_range(1) == 1) ? rand_digit() : rand_op());
          end
        end
        2:       expr_chars.push_back(rand_op());
        default: expr_chars.push_back(rand_digit());
      endcase
    end
    if (expr_chars.size() == 0 || $urandom_range(1) == 1) add_sep();
  endfunction

  task automatic run_random_phase(input int unsigned n_chars);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      if ($urandom_range(49) == 0) wait_drained();
      pick = $urandom_range(99);
      if (pick < 62) begin
        build_wellformed($urandom_range(6, 1), 1'b0);
      end else if (pick < 68) begin
        build_wellformed($urandom_range(16, 2), 1'b1);
      end else if (pick < 69) begin
        build_wellformed($urandom_range(StackDepth + 1, StackDepth - 4), 1'b1);
      end else if (pick < 71) begin
        queue_min_value();
        case ($urandom_range(2))
          0:       queue_text(" 0 1 - /");
          1:       queue_text(" 1 -");
          default: begin
            add_sep();
            expr_chars.push_back(rand_digit());
            add_sep();
            expr_chars.push_back(rand_op());
          end
        endcase
      end else if (pick < 82) begin
        build_wellformed($urandom_range(5, 1), 1'b0);
        add_sep();
        expr_chars.push_back(($urandom_range(1) == 1) ? rand_op() : rand_digit());
      end else begin
        build_noise();
      end
      send_expr();
    end
    wait_drained();
  endtask

  task automatic test_field_extremes();
    expr_chars.push_back(8'h00);
    send_expr();
    expr_chars.push_back(8'hFF);
    send_expr();
    queue_text("5");
    send_expr();
    for (int c = CharTab; c <= CharCr; c++) expr_chars.push_back(8'(c));
    expr_chars.push_back(CharSpace);
    send_expr();
  endtask

  task automatic test_operators();
    queue_text("7 5 -");
    send_expr();
    queue_text("0 9 - ");
    send_expr();
    queue_text("6 7 *");
    send_expr();
    queue_text("9 2 /");
    send_expr();
    queue_text("0 7 - 2 /");
    send_expr();
    queue_text("7 0 2 - / 3 +");
    send_expr();
  endtask

  task automatic test_token_errors();
    queue_text("12 3 +");
    send_expr();
    queue_text("3 +");
    send_expr();
    queue_text("3 a");
    send_expr();
    queue_text("3 4");
    send_expr();
    queue_text("1 0 / x");
    send_expr();
    queue_text("x 1 0 /");
    send_expr();
  endtask

  task automatic test_arith_corners();
    queue_text("9 0 /");
    send_expr();
    queue_min_value();
    queue_text(" 0 1 - /");
    send_expr();
    queue_min_value();
    queue_text(" 1 - ");
    send_expr();
    queue_min_value();
    queue_text(" 2 /");
    send_expr();
  endtask

  task automatic test_stack_limits();
    build_wellformed(StackDepth, 1'b1);
    send_expr();
    build_wellformed(StackDepth + 1, 1'b1);
    send_expr();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    in_idle_pct   = 10;
    out_stall_pct = 47;
    run_random_phase(400);
    in_idle_pct   = 47;
    out_stall_pct = 10;
    run_random_phase(400);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_random_phase(400);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    in_idle_pct   = 10;
    out_stall_pct = 47;
    test_field_extremes();
    test_operators();
    test_token_errors();
    test_arith_corners();
    test_stack_limits();
    test_random_traffic();
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (expr_results_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expr_results_q.size()));
    end
    $display("Summary: %0d characters sent, %0d expression results checked",
             chars_sent, results_checked);
    $display("Statuses: ok %0d, invalid %0d, divide by zero %0d, overflow %0d",
             status_seen[STATUS_OK], status_seen[STATUS_INVALID],
             status_seen[STATUS_DIVZERO], status_seen[STATUS_OVERFLOW]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_ram.sv
rtl/core/rpn_divider.sv
rtl/core/rpn_stack_evaluator_unit.sv
tb/sv/tb_top.sv
